// ----- hdl/tase_pkg.sv -----
`timescale 1ns / 1ps

package tase_pkg;

    localparam int NUM_VARS   = 128;
    localparam int NUM_LINES  = 256;
    localparam int DATA_WIDTH = 32;
    localparam int VAR_W      = $clog2(NUM_VARS);
    localparam int LINE_W     = $clog2(NUM_LINES);

    localparam logic [LINE_W-1:0] START_LINE = LINE_W'(2);

    // request functions
    localparam logic [1:0] FUNC_WRITE_VAR  = 2'd0;
    localparam logic [1:0] FUNC_WRITE_STMT = 2'd1;
    localparam logic [1:0] FUNC_RESTART    = 2'd2;
    localparam logic [1:0] FUNC_STEP       = 2'd3;

    // statement kinds
    localparam logic [2:0] KIND_STOP   = 3'd0;
    localparam logic [2:0] KIND_IF     = 3'd1;
    localparam logic [2:0] KIND_GOTO   = 3'd2;
    localparam logic [2:0] KIND_PRINT  = 3'd3;
    localparam logic [2:0] KIND_ASSIGN = 3'd4;

    // operators
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_MOD = 4'd4;
    localparam logic [3:0] OP_EQ  = 4'd5;
    localparam logic [3:0] OP_NE  = 4'd6;
    localparam logic [3:0] OP_LT  = 4'd7;
    localparam logic [3:0] OP_GT  = 4'd8;
    localparam logic [3:0] OP_LE  = 4'd9;
    localparam logic [3:0] OP_GE  = 4'd10;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
    localparam logic [1:0] ERR_BAD_OP   = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [6:0]         var_index;
        logic signed [31:0] var_value;
        logic [7:0]         line_index;
        logic [2:0]         stmt_kind;
        logic [6:0]         first_operand;
        logic [6:0]         second_operand;
        logic [3:0]         op_code;
        logic [7:0]         jump_line;
        logic [6:0]         dest_var;
    } req_t;

    typedef struct packed {
        logic               printed;
        logic signed [31:0] print_value;
        logic               halted;
        logic [7:0]         current_line;
        logic [1:0]         error_code;
    } rsp_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] first_operand;
        logic [6:0] second_operand;
        logic [3:0] op_code;
        logic [7:0] jump_line;
        logic [6:0] dest_var;
    } stmt_t;

endpackage

// ----- hdl/tase_divider.sv -----
`timescale 1ns / 1ps

module tase_divider
    import tase_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] dvs_reg, dvs_next;

    logic [DATA_WIDTH:0] rem_shift;
    logic [DATA_WIDTH:0] diff;

    // one restoring step a cycle, quotient bits shift in from the bottom
    assign rem_shift = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_WIDTH);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_WIDTH])
            begin
                rem_next = diff[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- hdl/three_address_statement_executor.sv -----
`timescale 1ns / 1ps

// channel    handshake              payload   moves
// request    req_valid/req_ready    req_data  one function: write, restart or step
// response   rsp_valid/rsp_ready    rsp_data  one result per request
//
// writes and restart go from acceptance through the finish state to the response register.
// a step goes through statement read, two variable reads, execute and response.
// divide and remainder also pass through the shared restoring divider.
// a new request is taken only in idle; a response waiting in the output
// register does not block acceptance, only the hand-over of the next result.
// reset clears line to 2, halt and error; both stores are uninitialised.

module three_address_statement_executor
    import tase_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_READA  = 6'b000100,
        S_EXEC   = 6'b001000,
        S_DIV    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [LINE_W-1:0]     line_reg, line_next;
    logic                  halt_reg, halt_next;
    logic [1:0]            err_reg, err_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic                  pflag_reg, pflag_next;
    logic [DATA_WIDTH-1:0] pval_reg, pval_next;
    logic                  neg_reg, neg_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_data_reg, rsp_data_next;

    logic [DATA_WIDTH-1:0] var_mem [NUM_VARS];
    stmt_t                 stmt_mem [NUM_LINES];
    logic [DATA_WIDTH-1:0] var_rd_reg;
    stmt_t                 stmt_rd_reg;

    logic                  var_we;
    logic [VAR_W-1:0]      var_waddr;
    logic [DATA_WIDTH-1:0] var_wdata;
    logic [VAR_W-1:0]      var_raddr;
    logic                  stmt_we;
    stmt_t                 stmt_wdata;

    logic                  div_start;
    logic                  div_done;
    logic [DATA_WIDTH-1:0] div_quo;
    logic [DATA_WIDTH-1:0] div_rem;
    logic [DATA_WIDTH-1:0] div_a;
    logic [DATA_WIDTH-1:0] div_b;
    logic [DATA_WIDTH-1:0] div_pick;

    logic [DATA_WIDTH-1:0] y_val;
    logic                  lt_xy;
    logic                  lt_yx;
    logic                  cond;

    assign y_val = var_rd_reg;
    assign lt_xy = $signed(x_reg) < $signed(y_val);
    assign lt_yx = $signed(y_val) < $signed(x_reg);

    always_comb
    begin
        case (stmt_rd_reg.op_code)
            OP_EQ:   cond = (x_reg == y_val);
            OP_NE:   cond = (x_reg != y_val);
            OP_LT:   cond = lt_xy;
            OP_GT:   cond = lt_yx;
            OP_LE:   cond = !lt_yx;
            default: cond = !lt_xy;
        endcase
    end

    // magnitudes for the unsigned divider
    assign div_a    = x_reg[DATA_WIDTH-1] ? (-x_reg) : x_reg;
    assign div_b    = y_val[DATA_WIDTH-1] ? (-y_val) : y_val;
    assign div_pick = (stmt_rd_reg.op_code == OP_DIV) ? div_quo : div_rem;

    assign stmt_wdata = '{kind:           req_data.stmt_kind,
                          first_operand:  req_data.first_operand,
                          second_operand: req_data.second_operand,
                          op_code:        req_data.op_code,
                          jump_line:      req_data.jump_line,
                          dest_var:       req_data.dest_var};

    tase_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        line_next      = line_reg;
        halt_next      = halt_reg;
        err_next       = err_reg;
        x_next         = x_reg;
        pflag_next     = pflag_reg;
        pval_next      = pval_reg;
        neg_next       = neg_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;
        var_we         = 1'b0;
        var_waddr      = stmt_rd_reg.dest_var;
        var_wdata      = '0;
        var_raddr      = stmt_rd_reg.first_operand;
        stmt_we        = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pflag_next = 1'b0;
                    pval_next  = '0;
                    state_next = S_FINISH;
                    unique case (req_data.func)
                        FUNC_WRITE_VAR:
                        begin
                            var_we    = 1'b1;
                            var_waddr = req_data.var_index;
                            var_wdata = req_data.var_value;
                        end
                        FUNC_WRITE_STMT:
                        begin
                            stmt_we = 1'b1;
                        end
                        FUNC_RESTART:
                        begin
                            line_next = START_LINE;
                            halt_next = 1'b0;
                            err_next  = ERR_NONE;
                        end
                        default:
                        begin
                            if (!halt_reg)
                                state_next = S_FETCH;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                // print needs only the printed slot, taken through the first read
                if (stmt_rd_reg.kind == KIND_PRINT)
                    var_raddr = stmt_rd_reg.dest_var;
                state_next = S_READA;
            end
            S_READA:
            begin
                x_next     = var_rd_reg;
                var_raddr  = stmt_rd_reg.second_operand;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
                unique case (stmt_rd_reg.kind)
                    KIND_STOP:
                    begin
                        halt_next = 1'b1;
                    end
                    KIND_IF:
                    begin
                        case (stmt_rd_reg.op_code) inside
                            [OP_EQ:OP_GE]:
                                line_next = cond ? stmt_rd_reg.jump_line
                                                 : line_reg + 1'b1;
                            default:
                            begin
                                halt_next = 1'b1;
                                err_next  = ERR_BAD_OP;
                            end
                        endcase
                    end
                    KIND_GOTO:
                    begin
                        line_next = stmt_rd_reg.jump_line;
                    end
                    KIND_PRINT:
                    begin
                        pflag_next = 1'b1;
                        pval_next  = x_reg;
                        line_next  = line_reg + 1'b1;
                    end
                    KIND_ASSIGN:
                    begin
                        unique case (stmt_rd_reg.op_code) inside
                            OP_ADD, OP_SUB, OP_MUL:
                            begin
                                var_we = 1'b1;
                                if (stmt_rd_reg.op_code == OP_ADD)
                                    var_wdata = x_reg + y_val;
                                else if (stmt_rd_reg.op_code == OP_SUB)
                                    var_wdata = x_reg - y_val;
                                else
                                    var_wdata = x_reg * y_val;
                                line_next = line_reg + 1'b1;
                            end
                            OP_DIV, OP_MOD:
                            begin
                                if (y_val == '0)
                                begin
                                    halt_next = 1'b1;
                                    err_next  = ERR_DIV_ZERO;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                    // quotient sign from both operands, remainder from dividend
                                    if (stmt_rd_reg.op_code == OP_DIV)
                                        neg_next = x_reg[DATA_WIDTH-1] ^ y_val[DATA_WIDTH-1];
                                    else
                                        neg_next = x_reg[DATA_WIDTH-1];
                                end
                            end
                            default:
                            begin
                                halt_next = 1'b1;
                                err_next  = ERR_BAD_OP;
                            end
                        endcase
                    end
                    default:
                    begin
                        halt_next = 1'b1;
                        err_next  = ERR_BAD_OP;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    var_we     = 1'b1;
                    var_wdata  = neg_reg ? (-div_pick) : div_pick;
                    line_next  = line_reg + 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = '{printed:      pflag_reg,
                                       print_value:  pval_reg,
                                       halted:       halt_reg,
                                       current_line: line_reg,
                                       error_code:   err_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            line_reg      <= START_LINE;
            halt_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
            pflag_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_reg      <= line_next;
            halt_reg      <= halt_next;
            err_reg       <= err_next;
            pflag_reg     <= pflag_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        pval_reg     <= pval_next;
        neg_reg      <= neg_next;
        rsp_data_reg <= rsp_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (var_we)
            var_mem[var_waddr] <= var_wdata;
        var_rd_reg <= var_mem[var_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stmt_we)
            stmt_mem[req_data.line_index] <= stmt_wdata;
        stmt_rd_reg <= stmt_mem[line_reg];
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_err_halts : assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE) |-> halt_reg)
        else $error("error latched without halt");

    a_halted_step_keeps_line : assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_data.func == FUNC_STEP && halt_reg)
        |=> (line_reg == $past(line_reg) && halt_reg && state_reg == S_FINISH))
        else $error("step while halted changed state");

    a_div_done_in_div : assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_div_start_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == S_EXEC && y_val != '0))
        else $error("divider started with zero divisor");

endmodule
